// File: hdl/assert_macros.svh
// assertion macros for the text encoding detector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define CHK_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define CHK_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hdl/ted_pkg.sv
// types, constants and byte-order mark matching for the text encoding detector
package ted_pkg;

  // verdict codes
  typedef enum logic [2:0] {
    ENC_NONE    = 3'd0,
    ENC_UTF8    = 3'd1,
    ENC_UTF7    = 3'd2,
    ENC_UTF16LE = 3'd3,
    ENC_UTF16BE = 3'd4
  } enc_t;

  // first four bytes of a buffer
  typedef logic [3:0][7:0] head_t;

  localparam int unsigned HEAD_DEPTH = 4;
  localparam int unsigned CNT_W      = 3;

  // utf-8 lead classes and limits
  localparam logic [7:0] LEAD_C0    = 8'hC0;
  localparam logic [7:0] LEAD_C1    = 8'hC1;
  localparam logic [7:0] LEAD_F5    = 8'hF5;
  localparam logic [1:0] TAIL_BITS  = 2'b10;

  // mark bytes
  localparam logic [7:0] BOM8_0  = 8'hEF;
  localparam logic [7:0] BOM8_1  = 8'hBB;
  localparam logic [7:0] BOM8_2  = 8'hBF;
  localparam logic [7:0] BOM7_0  = 8'h2B;
  localparam logic [7:0] BOM7_1  = 8'h2F;
  localparam logic [7:0] BOM7_2  = 8'h76;
  localparam logic [7:0] BOM7_3A = 8'h38;
  localparam logic [7:0] BOM7_3B = 8'h39;
  localparam logic [7:0] BOM7_3C = 8'h2B;
  localparam logic [7:0] BOM7_3D = 8'h2F;
  localparam logic [7:0] BOM_FF  = 8'hFF;
  localparam logic [7:0] BOM_FE  = 8'hFE;

  // match the byte-order marks in priority order
  function automatic enc_t mark_code(head_t h, logic [CNT_W-1:0] cnt);
    enc_t res;
    res = ENC_NONE;
    if (cnt >= CNT_W'(3) && h[0] == BOM8_0 && h[1] == BOM8_1 && h[2] == BOM8_2) begin
      res = ENC_UTF8;
    end else if (cnt >= CNT_W'(4) && h[0] == BOM7_0 && h[1] == BOM7_1 && h[2] == BOM7_2 &&
                 (h[3] == BOM7_3A || h[3] == BOM7_3B ||
                  h[3] == BOM7_3C || h[3] == BOM7_3D)) begin
      res = ENC_UTF7;
    end else if (cnt >= CNT_W'(2) && h[0] == BOM_FF && h[1] == BOM_FE) begin
      res = ENC_UTF16LE;
    end else if (cnt >= CNT_W'(2) && h[0] == BOM_FE && h[1] == BOM_FF) begin
      res = ENC_UTF16BE;
    end
    return res;
  endfunction

endpackage

// File: hdl/text_encoding_detector.sv
// text encoding detector: byte stream in, one encoding verdict per buffer out
//
// Takes one byte of a text buffer per cycle (s_tlast marks the final byte) and gives
// one verdict request per buffer: byte-order marks for UTF-8, UTF-7, UTF-16 LE and
// UTF-16 BE win, otherwise a NUL byte means UTF-16 LE and clean UTF-8 with high bytes
// means UTF-8. Every byte is held in the input register while the scan logic works on it;
// the verdict is loaded into the output register as the final byte leaves the input register.
// Sustained rate is one byte per cycle; the input side only stalls
// when a final byte reaches the scan stage while the previous verdict is still untaken.
`include "assert_macros.svh"

module text_encoding_detector
  import ted_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // byte input
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // final_byte
  // verdict output
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [2:0] encoding, [3] from_mark, [4] utf8_clean,
                                // [5] nul_seen, [6] high_seen, [7] zero
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // scan state
  head_t            head_bytes;
  logic [CNT_W-1:0] head_count;
  logic [1:0]       tails_pending;
  logic             utf8_ok;
  logic             nul_flag;
  logic             high_flag;

  // next values
  head_t            head_bytes_next;
  logic [CNT_W-1:0] head_count_next;
  logic [1:0]       tails_pending_next;
  logic             utf8_ok_next;
  logic             nul_flag_next;
  logic             high_flag_next;

  logic       advance;
  logic       ok_final;
  enc_t       mark_enc;
  enc_t       enc_final;
  logic [7:0] verdict;

  // stage moves unless a final byte meets a stalled verdict
  assign advance  = !(in_last && m_tvalid && !m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // head capture
  always_comb begin
    head_bytes_next = head_bytes;
    head_count_next = head_count;
    if (head_count < CNT_W'(HEAD_DEPTH)) begin
      head_bytes_next[head_count[1:0]] = in_byte;
      head_count_next = head_count + CNT_W'(1);
    end
  end

  // utf-8 scan of one byte
  always_comb begin
    tails_pending_next = tails_pending;
    utf8_ok_next       = utf8_ok;
    nul_flag_next      = nul_flag;
    high_flag_next     = high_flag | in_byte[7];
    if (tails_pending != 2'd0) begin
      if (in_byte[7:6] == TAIL_BITS) begin
        tails_pending_next = tails_pending - 2'd1;
      end else begin
        utf8_ok_next       = 1'b0;
        tails_pending_next = 2'd0;
      end
    end else if (in_byte == 8'd0) begin
      nul_flag_next = 1'b1;
    end else if (in_byte[7] && utf8_ok) begin
      if (!in_byte[6]) begin
        utf8_ok_next = 1'b0;
      end else if (!in_byte[5]) begin
        tails_pending_next = 2'd1;
        if (in_byte == LEAD_C0 || in_byte == LEAD_C1) utf8_ok_next = 1'b0;
      end else if (!in_byte[4]) begin
        tails_pending_next = 2'd2;
      end else if (!in_byte[3]) begin
        tails_pending_next = 2'd3;
        if (in_byte >= LEAD_F5) utf8_ok_next = 1'b0;
      end else begin
        utf8_ok_next = 1'b0;
      end
    end
  end

  // verdict for a buffer ending with this byte
  always_comb begin
    ok_final = utf8_ok_next && (tails_pending_next == 2'd0);
    mark_enc = mark_code(head_bytes_next, head_count_next);
    if (mark_enc != ENC_NONE) begin
      enc_final = mark_enc;
    end else if (nul_flag_next) begin
      enc_final = ENC_UTF16LE;
    end else if (high_flag_next && ok_final) begin
      enc_final = ENC_UTF8;
    end else begin
      enc_final = ENC_NONE;
    end
    verdict = {1'b0, high_flag_next, nul_flag_next, ok_final,
               (mark_enc != ENC_NONE), enc_final};
  end

  // scan state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      head_bytes    <= '0;
      head_count    <= '0;
      tails_pending <= 2'd0;
      utf8_ok       <= 1'b1;
      nul_flag      <= 1'b0;
      high_flag     <= 1'b0;
    end else if (in_valid && advance) begin
      if (in_last) begin
        head_bytes    <= '0;
        head_count    <= '0;
        tails_pending <= 2'd0;
        utf8_ok       <= 1'b1;
        nul_flag      <= 1'b0;
        high_flag     <= 1'b0;
      end else begin
        head_bytes    <= head_bytes_next;
        head_count    <= head_count_next;
        tails_pending <= tails_pending_next;
        utf8_ok       <= utf8_ok_next;
        nul_flag      <= nul_flag_next;
        high_flag     <= high_flag_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_valid && in_last && advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (in_valid && in_last && advance) begin
      m_tdata <= verdict;
    end
  end

  // checks
  `CHK_SAME(a_head_cnt, 1'b1, head_count <= CNT_W'(HEAD_DEPTH))
  `CHK_SAME(a_enc_range, m_tvalid, m_tdata[2:0] <= ENC_UTF16BE)
  `CHK_SAME(a_nul_le, m_tvalid && !m_tdata[3] && m_tdata[5], m_tdata[2:0] == ENC_UTF16LE)
  `CHK_SAME(a_utf8_clean, m_tvalid && !m_tdata[3] && m_tdata[2:0] == ENC_UTF8,
            m_tdata[4] && m_tdata[6])
  `CHK_NEXT(a_clear, in_valid && in_last && advance,
            m_tvalid && head_count == '0 && utf8_ok && !nul_flag && !high_flag)

endmodule

// File: tb/sv/text_encoding_detector_tb.sv
// testbench for the text encoding detector: byte stream stimulus, verdict prediction and checks
`timescale 1ns / 1ps

module text_encoding_detector_tb;
  import ted_pkg::*;

  // verdict word as it travels on m_tdata, encoding in the low bits
  typedef struct packed {
    logic pad;
    logic high;
    logic nul;
    logic clean;
    logic from_mark;
    enc_t enc;
  } verdict_t;

  // one row of the directed table
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       typed;
    verdict_t   want;
  } text_row_t;

  // handshake pressure per phase
  typedef enum int {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SINK_STALL,
    FLOW_BOTH
  } flow_t;

  localparam int       STALL_LIMIT  = 4000;
  localparam int       PHASE_BYTES  = 230;
  localparam int       DRAIN_CYCLES = 12;
  localparam verdict_t NO_VERDICT   = '0;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  // predictor state for the buffer in flight
  head_t      head;
  logic [2:0] head_cnt;
  logic [1:0] tails_left;
  logic       scan_ok;
  logic       nul_flag;
  logic       hi_flag;

  verdict_t   verdict_q[$];
  logic [7:0] text_q[$];
  int         src_idle_pct;
  int         sink_stall_pct;
  int         bytes_sent;
  int         verdicts_seen = 0;
  int         errors = 0;
  int         quiet_cycles = 0;
  verdict_t   got_v;
  verdict_t   want_v;

  text_encoding_detector u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic verdict_t verdict(enc_t enc, logic mark, logic clean, logic nul,
                                       logic high);
    verdict_t v;
    v = NO_VERDICT;
    v.enc       = enc;
    v.from_mark = mark;
    v.clean     = clean;
    v.nul       = nul;
    v.high      = high;
    return v;
  endfunction

  function automatic text_row_t row(logic [7:0] data, logic last, logic typed, verdict_t want);
    text_row_t r;
    r.data  = data;
    r.last  = last;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic logic [7:0] tail_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // predictor: back to the state of an empty buffer
  task automatic clear_text_state();
    head       = '0;
    head_cnt   = '0;
    tails_left = '0;
    scan_ok    = 1'b1;
    nul_flag   = 1'b0;
    hi_flag    = 1'b0;
  endtask

  // byte-order mark lookup over the kept head bytes, first match wins
  function automatic enc_t bom_lookup();
    enc_t e;
    e = ENC_NONE;
    if (head_cnt >= 3'd3 && head[0] == BOM8_0 && head[1] == BOM8_1 && head[2] == BOM8_2)
      e = ENC_UTF8;
    else if (head_cnt >= 3'd4 && head[0] == BOM7_0 && head[1] == BOM7_1 &&
             head[2] == BOM7_2 && (head[3] == BOM7_3A || head[3] == BOM7_3B ||
             head[3] == BOM7_3C || head[3] == BOM7_3D))
      e = ENC_UTF7;
    else if (head_cnt >= 3'd2 && head[0] == BOM_FF && head[1] == BOM_FE)
      e = ENC_UTF16LE;
    else if (head_cnt >= 3'd2 && head[0] == BOM_FE && head[1] == BOM_FF)
      e = ENC_UTF16BE;
    return e;
  endfunction

  // predictor: take one byte, give the verdict when it closes the buffer
  task automatic classify_byte(input logic [7:0] b, input logic last, output logic done,
                               output verdict_t v);
    enc_t mark;
    done = 1'b0;
    v    = NO_VERDICT;
    if (head_cnt < 3'd4) begin
      head[head_cnt[1:0]] = b;
      head_cnt = head_cnt + 3'd1;
    end
    if (b[7]) hi_flag = 1'b1;
    // utf-8 scan: tails first, then nul, then leads while still clean
    if (tails_left != 2'd0) begin
      if (b[7:6] == TAIL_BITS) begin
        tails_left = tails_left - 2'd1;
      end else begin
        scan_ok    = 1'b0;
        tails_left = 2'd0;
      end
    end else if (b == 8'h00) begin
      nul_flag = 1'b1;
    end else if (b[7] && scan_ok) begin
      if (!b[6]) begin
        scan_ok = 1'b0;
      end else if (!b[5]) begin
        tails_left = 2'd1;
        if (b == LEAD_C0 || b == LEAD_C1) scan_ok = 1'b0;
      end else if (!b[4]) begin
        tails_left = 2'd2;
      end else if (!b[3]) begin
        tails_left = 2'd3;
        if (b >= LEAD_F5) scan_ok = 1'b0;
      end else begin
        scan_ok = 1'b0;
      end
    end
    if (last) begin
      if (tails_left != 2'd0) scan_ok = 1'b0;
      mark        = bom_lookup();
      v.from_mark = (mark != ENC_NONE);
      if (v.from_mark) v.enc = mark;
      else if (nul_flag) v.enc = ENC_UTF16LE;
      else if (hi_flag && scan_ok) v.enc = ENC_UTF8;
      else v.enc = ENC_NONE;
      v.clean = scan_ok;
      v.nul   = nul_flag;
      v.high  = hi_flag;
      done    = 1'b1;
      clear_text_state();
    end
  endtask

  task automatic set_flow(flow_t f);
    src_idle_pct   = (f == FLOW_SRC_IDLE) ? 74 : (f == FLOW_BOTH) ? 7 : 0;
    sink_stall_pct = (f == FLOW_SINK_STALL) ? 74 : (f == FLOW_BOTH) ? 7 : 0;
  endtask

  // drive one byte request from a falling edge, return at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input verdict_t want);
    logic     done;
    verdict_t v;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    classify_byte(b, last, done, v);
    if (done) verdict_q.push_back(typed ? want : v);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sender pause until every pending verdict has come out
  task automatic hold_until_drained();
    s_tvalid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
  endtask

  // random buffer: optional mark, then mostly well-formed text with some broken pieces
  task automatic build_buffer();
    int         n_chars;
    int         pick;
    int         n_tails;
    logic [7:0] lead;
    text_q.delete();
    n_chars = $urandom_range(1, 9);
    case ($urandom_range(11))
      0: begin
        text_q.push_back(BOM8_0);
        text_q.push_back(BOM8_1);
        text_q.push_back(BOM8_2);
      end
      1, 4: begin
        text_q.push_back(BOM7_0);
        text_q.push_back(BOM7_1);
        text_q.push_back(BOM7_2);
        case ($urandom_range(4))
          0: text_q.push_back(BOM7_3A);
          1: text_q.push_back(BOM7_3B);
          2: text_q.push_back(BOM7_3C);
          3: text_q.push_back(BOM7_3D);
          default: text_q.push_back(8'($urandom_range(255)));
        endcase
      end
      2: begin
        text_q.push_back(BOM_FF);
        text_q.push_back(BOM_FE);
      end
      3: begin
        text_q.push_back(BOM_FE);
        text_q.push_back(BOM_FF);
      end
      // marks cut short by the end of the buffer
      5: begin
        text_q.push_back(BOM8_0);
        text_q.push_back(BOM8_1);
        n_chars = 0;
      end
      6: begin
        text_q.push_back(BOM7_0);
        text_q.push_back(BOM7_1);
        text_q.push_back(BOM7_2);
        n_chars = 0;
      end
      7: begin
        text_q.push_back($urandom_range(1) ? BOM_FF : BOM_FE);
        n_chars = 0;
      end
      default: ;
    endcase
    repeat (n_chars) begin
      pick    = $urandom_range(19);
      n_tails = 0;
      if (pick < 8) begin
        lead = 8'($urandom_range(1, 127));
      end else if (pick < 14) begin
        n_tails = $urandom_range(1, 3);
        case (n_tails)
          1: lead = 8'($urandom_range(8'hC2, 8'hDF));
          2: lead = 8'($urandom_range(8'hE0, 8'hEF));
          default: lead = 8'($urandom_range(8'hF0, 8'hF4));
        endcase
      end else if (pick == 14) begin
        lead = 8'h00;
      end else if (pick == 15) begin
        lead = 8'($urandom_range(255));
      end else if (pick == 16) begin
        // sequence missing tails
        lead    = 8'($urandom_range(8'hE0, 8'hF4));
        n_tails = 1;
      end else if (pick == 17) begin
        // overlong or out-of-range lead with its tails
        lead    = $urandom_range(1) ? 8'($urandom_range(LEAD_C0, LEAD_C1))
                                    : 8'($urandom_range(LEAD_F5, 8'hF7));
        n_tails = (lead < 8'hE0) ? 1 : 3;
      end else if (pick == 18) begin
        lead = 8'($urandom_range(8'h80, 8'hBF));
      end else begin
        lead = 8'($urandom_range(8'hF8, 8'hFF));
      end
      text_q.push_back(lead);
      repeat (n_tails) text_q.push_back(tail_byte());
    end
  endtask

  function automatic void cmp_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // verdict side ready pattern
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // verdict request check against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_v = verdict_t'(m_tdata);
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: verdict with none expected, expected nothing actual %02h",
                 $time, m_tdata);
      end else begin
        want_v = verdict_q.pop_front();
        cmp_field("encoding", want_v.enc, got_v.enc);
        cmp_field("from_mark", 3'(want_v.from_mark), 3'(got_v.from_mark));
        cmp_field("utf8_clean", 3'(want_v.clean), 3'(got_v.clean));
        cmp_field("nul_seen", 3'(want_v.nul), 3'(got_v.nul));
        cmp_field("high_seen", 3'(want_v.high), 3'(got_v.high));
        cmp_field("pad bit", 3'd0, 3'(got_v.pad));
      end
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    text_row_t dir_rows[$];
    flow_t     modes[4];
    int        phase_start;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    bytes_sent     = 0;
    sink_stall_pct = 0;
    src_idle_pct   = 0;
    clear_text_state();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed buffers: lone nul, ascii, every mark, cut marks, bad leads and tails
    dir_rows = '{
      row(8'h00, 1'b1, 1'b1, verdict(ENC_UTF16LE, 1'b0, 1'b1, 1'b1, 1'b0)),
      row(8'h7F, 1'b1, 1'b0, NO_VERDICT),
      row(8'hFF, 1'b0, 1'b0, NO_VERDICT),
      row(8'hFE, 1'b1, 1'b1, verdict(ENC_UTF16LE, 1'b1, 1'b0, 1'b0, 1'b1)),
      row(8'hFE, 1'b0, 1'b0, NO_VERDICT),
      row(8'hFF, 1'b1, 1'b1, verdict(ENC_UTF16BE, 1'b1, 1'b0, 1'b0, 1'b1)),
      row(8'hEF, 1'b0, 1'b0, NO_VERDICT),
      row(8'hBB, 1'b0, 1'b0, NO_VERDICT),
      row(8'hBF, 1'b1, 1'b0, NO_VERDICT),
      row(8'h2B, 1'b0, 1'b0, NO_VERDICT),
      row(8'h2F, 1'b0, 1'b0, NO_VERDICT),
      row(8'h76, 1'b0, 1'b0, NO_VERDICT),
      row(8'h2F, 1'b1, 1'b0, NO_VERDICT),
      row(8'hEF, 1'b0, 1'b0, NO_VERDICT),
      row(8'hBB, 1'b1, 1'b0, NO_VERDICT),
      row(8'hC2, 1'b0, 1'b0, NO_VERDICT),
      row(8'h00, 1'b1, 1'b0, NO_VERDICT),
      row(8'hC1, 1'b0, 1'b0, NO_VERDICT),
      row(8'hBF, 1'b1, 1'b0, NO_VERDICT),
      row(8'hF0, 1'b0, 1'b0, NO_VERDICT),
      row(8'h9F, 1'b0, 1'b0, NO_VERDICT),
      row(8'h98, 1'b0, 1'b0, NO_VERDICT),
      row(8'h80, 1'b1, 1'b0, NO_VERDICT),
      row(8'hF8, 1'b1, 1'b1, verdict(ENC_NONE, 1'b0, 1'b0, 1'b0, 1'b1)),
      row(8'h80, 1'b1, 1'b1, verdict(ENC_NONE, 1'b0, 1'b0, 1'b0, 1'b1))
    };
    set_flow(FLOW_FREE);
    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    hold_until_drained();

    // random buffers under each handshake pressure
    modes = '{FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH};
    foreach (modes[k]) begin
      set_flow(modes[k]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_buffer();
        foreach (text_q[i])
          send_byte(text_q[i], i == text_q.size() - 1, 1'b0, NO_VERDICT);
      end
      hold_until_drained();
    end

    // let any stray verdict surface
    set_flow(FLOW_FREE);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes, checked %0d verdicts: marks, cut marks, nul, utf-8 scan cases",
             bytes_sent, verdicts_seen);
    $display("Flow modes: free, sender idle, receiver stall, both sides idling");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
